### src/srit_pkg.sv
package srit_pkg;

   // Item kinds on the request channel.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // Ordering key selected by the configuration register.
   localparam logic KEY_MOVES  = 1'b0;
   localparam logic KEY_FINISH = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [31:0] moves;
      logic [31:0] finish_ms;
      logic [7:0]  level;
      logic [5:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [5:0]  slot;
      logic [6:0]  count;
      logic        dropped;
      logic        valid_res;
      logic [31:0] out_moves;
      logic [31:0] out_finish_ms;
      logic [7:0]  out_level;
   } rsp_type;

   // One stored record as it sits in a table word.
   typedef struct packed {
      logic [31:0] moves;
      logic [31:0] finish_ms;
      logic [7:0]  level;
   } rec_type;

endpackage

### src/srit_ram.sv
module srit_ram #(
   parameter int WIDTH  = 72,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/srit_cmp.sv
module srit_cmp (
   input  logic             sort_by,
   input  srit_pkg::rec_type held_rec,
   input  srit_pkg::rec_type new_rec,
   output logic             held_lt
);
   import srit_pkg::*;

   logic [31:0] held_key;
   logic [31:0] new_key;

   // The one key comparator; every step of the search goes through it.
   always_comb begin
      if (sort_by == KEY_FINISH) begin
         held_key = held_rec.finish_ms;
         new_key  = new_rec.finish_ms;
      end else begin
         held_key = held_rec.moves;
         new_key  = new_rec.moves;
      end
      held_lt = held_key < new_key;
   end

endmodule

### src/sorted_record_insert_table.sv
// Insert: an upward search over the held records, then a downward shift; the search
//   ends without a compare when the record lands above all of them. Every record passed
//   costs a table read and a compare, every record moved a read and a write-back.
// A read of a held slot takes a table read; a read past the count or a refused insert none.
// One item at a time, taken once the last result is in the output register, later while
//   a stalled result blocks it. Reset clears the count, key select and handshake only.
module sorted_record_insert_table #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  srit_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output srit_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import srit_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CW > 6) ? CW : 6;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_READ_RD,
      S_READ_WAIT,
      S_DONE
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           sort_by_ff, sort_by_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic [AW-1:0]  idx_ff, idx_in;
   rec_type        rec_ff, rec_in;
   logic [5:0]     ri_ff, ri_in;
   rsp_type        res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   logic           ram_wr_en;
   logic [AW-1:0]  ram_wr_addr;
   rec_type        ram_wr_data;
   logic [AW-1:0]  ram_rd_addr;
   rec_type        ram_rd_data;
   logic           held_lt;
   logic           req_xfer;
   logic           rsp_slot_free;

   // Records live in one table, one record per word. Insert walks it twice:
   // first upward to find the first record whose key is not below the new
   // key, then downward from the top, moving each record up one slot until
   // the found slot is open.
   srit_ram #(
      .WIDTH($bits(rec_type)),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   srit_cmp u_cmp (
      .sort_by  (sort_by_ff),
      .held_rec (ram_rd_data),
      .new_rec  (rec_ff),
      .held_lt  (held_lt)
   );

   // The block takes a new item whenever the sequencer is idle; a finished
   // result may still be waiting in the output register at that time.
   assign req_stall     = (state_ff != S_IDLE);
   assign req_xfer      = req_valid && !req_stall;
   assign rsp_slot_free = !(rsp_valid_ff && rsp_stall);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

   // Table port control follows the state directly.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_addr = pos_ff;
      case (state_ff)
         S_SHIFT_RD: begin
            ram_rd_addr = idx_ff - AW'(1);
         end
         S_SHIFT_WR: begin
            ram_wr_en = 1'b1;
         end
         S_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = rec_ff;
         end
         S_READ_RD: begin
            ram_rd_addr = AW'(ri_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sort_by_in   = csr_wr_en ? csr_wr_data : sort_by_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      rec_in       = rec_ff;
      ri_in        = ri_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               rec_in = '{moves: req_data.moves, finish_ms: req_data.finish_ms,
                          level: req_data.level};
               ri_in  = req_data.read_index;
               res_in = '0;
               res_in.count = 7'(count_ff);
               pos_in = '0;
               idx_in = AW'(count_ff);
               if (req_data.kind == KIND_READ) begin
                  res_in.slot = req_data.read_index;
                  if (IW'(req_data.read_index) < IW'(count_ff)) begin
                     state_in = S_READ_RD;
                  end else begin
                     state_in = S_DONE;
                  end
               end else if (count_ff == CW'(CAPACITY)) begin
                  // Full table: the record is refused and nothing moves.
                  res_in.dropped = 1'b1;
                  state_in       = S_DONE;
               end else begin
                  state_in = S_SRCH_RD;
               end
            end
         end
         S_SRCH_RD: begin
            // Reached the end of the held records: append at the top.
            if (CW'(pos_ff) == count_ff) begin
               state_in = S_SHIFT_RD;
            end else begin
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (held_lt) begin
               pos_in   = pos_ff + AW'(1);
               state_in = S_SRCH_RD;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            if (idx_ff == pos_ff) begin
               state_in = S_PLACE;
            end else begin
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            idx_in   = idx_ff - AW'(1);
            state_in = S_SHIFT_RD;
         end
         S_PLACE: begin
            count_in     = count_ff + CW'(1);
            res_in.slot  = 6'(pos_ff);
            res_in.count = 7'(count_ff + CW'(1));
            state_in     = S_DONE;
         end
         S_READ_RD: begin
            state_in = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            res_in.valid_res     = 1'b1;
            res_in.out_moves     = ram_rd_data.moves;
            res_in.out_finish_ms = ram_rd_data.finish_ms;
            res_in.out_level     = ram_rd_data.level;
            state_in             = S_DONE;
         end
         S_DONE: begin
            // Hand the result over once the output register is free.
            if (rsp_slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sort_by_ff   <= KEY_MOVES;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sort_by_ff   <= sort_by_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      rec_ff      <= rec_in;
      ri_ff       <= ri_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### src/srit_chk.sv
module srit_chk #(
   parameter int CAPACITY = 64
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input srit_pkg::rsp_type rsp_data
);
   import srit_pkg::*;

   // A result waiting on a stalled consumer stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Every item keeps the block busy for at least the following cycle.
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken on consecutive cycles");

   // A refused insert only happens with a full table and names slot zero.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dropped |->
         rsp_data.count == 7'(CAPACITY) && rsp_data.slot == 6'd0 && !rsp_data.valid_res)
      else $error("bad refused-insert result");

   // Nothing is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("activity after reset");

endmodule

bind sorted_record_insert_table srit_chk #(.CAPACITY(CAPACITY)) u_srit_chk (.*);

### bench/sorted_table_checker.sv
module sorted_table_checker #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  srit_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  srit_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   output int                error_count,
   output int                replies_pending
);
   import srit_pkg::*;

   // Shadow copy of the record table, its fill level and the key select.
   rec_type held_recs [CAPACITY];
   int      held_n;
   logic    key_sel;
   rsp_type replies_due [$];

   initial begin
      error_count     = 0;
      replies_pending = 0;
      held_n          = 0;
      key_sel         = KEY_MOVES;
   end

   function automatic logic [31:0] sort_key(input rec_type r);
      return (key_sel == KEY_FINISH) ? r.finish_ms : r.moves;
   endfunction

   // Applies one request to the shadow table and returns the reply it earns.
   function automatic rsp_type insert_or_read(input req_type item);
      rsp_type reply;
      rec_type fresh;
      int      pos;
      reply = '0;
      if (item.kind == KIND_INSERT) begin
         if (held_n >= CAPACITY) begin
            reply.dropped = 1'b1;
         end else begin
            fresh = '{moves: item.moves, finish_ms: item.finish_ms, level: item.level};
            pos = 0;
            while (pos < held_n && sort_key(held_recs[pos]) < sort_key(fresh)) pos++;
            for (int i = held_n; i > pos; i--) held_recs[i] = held_recs[i - 1];
            held_recs[pos] = fresh;
            held_n++;
            reply.slot = 6'(pos);
         end
      end else begin
         reply.slot = item.read_index;
         if (int'(item.read_index) < held_n) begin
            reply.valid_res     = 1'b1;
            reply.out_moves     = held_recs[item.read_index].moves;
            reply.out_finish_ms = held_recs[item.read_index].finish_ms;
            reply.out_level     = held_recs[item.read_index].level;
         end
      end
      reply.count = 7'(held_n);
      return reply;
   endfunction

   task automatic note_failure(input string msg);
      $display("%s", msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         note_failure($sformatf("%s mismatch at %0t: got %0h, wanted %0h",
                                name, $time, got, want));
   endtask

   task automatic compare_reply(input rsp_type want, input rsp_type got);
      check_field("slot", 32'(got.slot), 32'(want.slot));
      check_field("count", 32'(got.count), 32'(want.count));
      check_field("dropped", 32'(got.dropped), 32'(want.dropped));
      check_field("valid_res", 32'(got.valid_res), 32'(want.valid_res));
      check_field("out_moves", got.out_moves, want.out_moves);
      check_field("out_finish_ms", got.out_finish_ms, want.out_finish_ms);
      check_field("out_level", 32'(got.out_level), 32'(want.out_level));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_n  = 0;
         key_sel = KEY_MOVES;
         replies_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0)
               note_failure($sformatf("reply at %0t with none outstanding", $time));
            else
               compare_reply(replies_due.pop_front(), rsp_data);
         end
         if (req_valid && !req_stall) replies_due.push_back(insert_or_read(req_data));
         if (csr_wr_en) key_sel = csr_wr_data;
      end
      replies_pending = replies_due.size();
   end

endmodule

### bench/tb_sorted_record_insert_table.sv
module tb_sorted_record_insert_table;
   import srit_pkg::*;

   localparam int CAPACITY = 64;
   localparam int PHASES   = 10;

   // Reply-side stall behaviors; the receiver switches among them on its own.
   localparam int STALL_NONE   = 0;
   localparam int STALL_COIN   = 1;
   localparam int STALL_HEAVY  = 2;
   localparam int STALL_SQUARE = 3;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;

   int error_count;
   int replies_pending;

   // Number of inserts the block has taken so far. It only steers read indexes
   // toward held slots; the checker keeps the exact table on its own.
   int inserts_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sorted_record_insert_table #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   sorted_table_checker #(
      .CAPACITY(CAPACITY)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .error_count    (error_count),
      .replies_pending(replies_pending)
   );

   // The receiver picks a stall behavior, holds it for a random stretch of
   // cycles and then picks again. Stretches with no stall at all are included,
   // and the heavy mode stalls the replies on most cycles.
   int stall_mode = STALL_NONE;
   int stall_left = 0;
   int stall_tick = 0;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(STALL_NONE, STALL_SQUARE);
         stall_left <= $urandom_range(20, 150);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_tick <= stall_tick + 1;
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_COIN: begin
            rsp_stall <= ($urandom_range(0, 1) == 0);
         end
         STALL_HEAVY: begin
            rsp_stall <= ($urandom_range(0, 9) < 8);
         end
         default: begin
            rsp_stall <= stall_tick[1];
         end
      endcase
   end

   function automatic req_type make_item(input logic kind, input logic [31:0] mv,
                                         input logic [31:0] ft, input logic [7:0] lv,
                                         input logic [5:0] ri);
      req_type item;
      item.kind       = kind;
      item.moves      = mv;
      item.finish_ms  = ft;
      item.level      = lv;
      item.read_index = ri;
      return item;
   endfunction

   // Key values lean toward a narrow range so that equal keys are common,
   // with the two extremes and full-width values mixed in.
   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2, 3, 4, 5: return 32'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   // Builds a random request. Reads mostly name a slot that is held, and
   // otherwise any index in the field's range, so both sides of the count
   // are covered. The fields a request does not use are random as well.
   function automatic req_type pick_item(input int insert_pct);
      int held = (inserts_sent < CAPACITY) ? inserts_sent : CAPACITY;
      logic [5:0] ri;
      if ($urandom_range(0, 99) < insert_pct)
         return make_item(KIND_INSERT, pick_key(), pick_key(),
                          8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
      if (held > 0 && $urandom_range(0, 99) < 80)
         ri = 6'($urandom_range(0, held - 1));
      else
         ri = 6'($urandom_range(0, 63));
      return make_item(KIND_READ, $urandom, $urandom, 8'($urandom_range(0, 255)), ri);
   endfunction

   // Called at a falling edge. The payload and valid stay put until the block
   // takes the transfer, and the task returns at the following falling edge
   // with valid still high, so back-to-back transfers need no extra step.
   task automatic send_item(input req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (item.kind == KIND_INSERT) inserts_sent++;
   endtask

   task automatic pause(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Holds off the sender until every reply has come back. Each request earns
   // exactly one reply, so the block is idle once the count reaches zero; spare
   // cycles are added before anything else touches it.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (replies_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // The key select is only written while the block is idle.
   task automatic set_key(input logic key);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= key;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int   burst_left;
      int   phase_items;
      logic key_now;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      set_key(KEY_MOVES);

      // Reads of an empty table, at the lowest and highest index, carrying
      // all-ones and all-zeros in the fields that a read ignores.
      send_item(make_item(KIND_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 6'd0));
      send_item(make_item(KIND_READ, 32'h0, 32'h0, 8'h00, 6'd63));

      // Ordered by moves: an equal key goes in front of the record already
      // held, then the smallest and the largest key, then one in the middle.
      send_item(make_item(KIND_INSERT, 32'd100, 32'd5, 8'd1, 6'h3F));
      send_item(make_item(KIND_INSERT, 32'd100, 32'd6, 8'd2, 6'd0));
      send_item(make_item(KIND_INSERT, 32'h0, 32'hFFFF_FFFF, 8'h00, 6'd0));
      send_item(make_item(KIND_INSERT, 32'hFFFF_FFFF, 32'h0, 8'hFF, 6'd0));
      send_item(make_item(KIND_INSERT, 32'd50, 32'd7, 8'd3, 6'd0));

      // Every held slot, then the first slot past the count.
      for (int i = 0; i < 6; i++)
         send_item(make_item(KIND_READ, 32'h0, 32'h0, 8'h00, 6'(i)));

      // Switch to finish time with records held: the table keeps its order
      // and later inserts scan it with the new key, ties included.
      set_key(KEY_FINISH);
      send_item(make_item(KIND_INSERT, 32'd7, 32'h0, 8'd4, 6'd0));
      send_item(make_item(KIND_INSERT, 32'd8, 32'hFFFF_FFFF, 8'd5, 6'd0));
      send_item(make_item(KIND_INSERT, 32'd9, 32'd6, 8'd6, 6'd0));
      for (int i = 0; i < 3; i++)
         send_item(make_item(KIND_READ, 32'h0, 32'h0, 8'h00, 6'(i)));
      send_item(make_item(KIND_READ, 32'h0, 32'h0, 8'h00, 6'd63));

      // Random phases, each under a key setting of its own. The first few are
      // short and insert-heavy, so the table fills while the key still moves
      // back and forth; the later ones run against a full table, where
      // inserts are dropped and reads reach every slot. Every phase change
      // waits for all replies, which also leaves the block idle.
      burst_left = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         key_now = (phase % 2 == 0) ? KEY_MOVES : KEY_FINISH;
         set_key(key_now);
         phase_items = (phase < 4) ? 30 : 180;
         for (int n = 0; n < phase_items; n++) begin
            // The sender works in bursts; most bursts are preceded by a gap,
            // the others follow straight on from the previous one.
            if (burst_left == 0) begin
               if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            send_item(pick_item((phase < 4) ? 75 : 40));
         end
      end

      // Wait for the last replies, then long enough for the slowest insert to
      // show up if the block were to send anything more.
      req_valid <= 1'b0;
      @(negedge clock);
      while (replies_pending != 0) @(negedge clock);
      repeat (2 * CAPACITY + 20) @(negedge clock);

      if (error_count == 0)
         $display("tb_sorted_record_insert_table: clean");
      else
         $display("tb_sorted_record_insert_table: errors");
      $finish;
   end

   // A stuck handshake ends the run here.
   initial begin
      #20_000_000;
      $display("tb_sorted_record_insert_table: errors");
      $finish;
   end

endmodule
